### rtl/particle_ground_bounce_core_assert.svh
// assertion macros used by the checker file of the particle ground bounce block
`ifndef PARTICLE_GROUND_BOUNCE_CORE_ASSERT_SVH
`define PARTICLE_GROUND_BOUNCE_CORE_ASSERT_SVH

// clocked assertion, masked while reset is low
`define PGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pgb_pkg.sv
// shared types, constants and saturation helpers of the particle ground bounce block
package pgb_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned Q_FRAC_BITS = 16;
    localparam int unsigned PROD_W      = 2 * WORD_W;
    localparam int unsigned SHIFT_W     = PROD_W - Q_FRAC_BITS;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_GROUND_HEIGHT = 1'b0,
        CFG_BOUNCE_SCALE  = 1'b1
    } t_cfg_index;

    // one particle word
    typedef struct packed {
        t_word            px;
        t_word            py;
        t_word            pz;
        t_word            vx;
        t_word            vy;
        t_word            vz;
        logic [CNT_W-1:0] bounces;
        logic             last;
    } t_particle;

    // particle plus the ground contact flag found at entry
    typedef struct packed {
        t_particle item;
        logic      below;
    } t_side;

    // load strobes of the two multiply stages
    typedef struct packed {
        logic load_mul;
        logic load_sat;
    } t_scale_ctl;

    // load strobes of the side pipeline and the output register
    typedef struct packed {
        logic load_s2;
        logic load_s3;
        logic load_out;
    } t_resolve_ctl;

    // clamp a shifted product to the word range
    function automatic t_word sat_shifted(input logic signed [SHIFT_W-1:0] v);
        t_word res;
        if ((v[SHIFT_W-1:WORD_W-1] == '0) || (v[SHIFT_W-1:WORD_W-1] == '1)) begin
            res = v[WORD_W-1:0];
        end else if (v[SHIFT_W-1]) begin
            res = WORD_MIN;
        end else begin
            res = WORD_MAX;
        end
        return res;
    endfunction

    // saturating word add
    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        t_word                  res;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            res = s[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            res = s[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/particle_ground_bounce_core.sv
// top level of the particle ground bounce block
//
// Input channel: one particle word (position, velocity, bounce budget, batch
// flag) is taken at a rising edge with i_valid high and o_stall low.
// Output channel: the updated particle is offered on o_valid and taken at an
// edge where i_stall is low. Each input word gives exactly one output word.
// Pipeline: four register stages (contact test, 32x32 multiply, shift and
// clamp, position update); the first loads at the accepting edge and
// o_valid is the valid bit of the last; each velocity axis has its own multiplier.
// Throughput: one word per cycle while i_stall does not hold the output.
// Stalls: each stage holds while the one after it is full and held, so
// bubbles close up and a full pipeline raises o_stall while i_stall holds
// the output word. Nothing is dropped or repeated.
// Configuration: i_cfg_we writes ground height (index 0) or bounce scale
// (index 1); write only while the pipeline is empty.
// Reset: synchronous, active low; empties the pipeline and sets ground
// height to 0 and bounce scale to 1.0.
module particle_ground_bounce_core
    import pgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [WORD_W-1:0]  i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_position_z,
    input  logic signed [31:0] i_velocity_x,
    input  logic signed [31:0] i_velocity_y,
    input  logic signed [31:0] i_velocity_z,
    input  logic [7:0]         i_bounces_left_in,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_position_x,
    output logic signed [31:0] o_new_position_y,
    output logic signed [31:0] o_new_position_z,
    output logic signed [31:0] o_new_velocity_x,
    output logic signed [31:0] o_new_velocity_y,
    output logic signed [31:0] o_new_velocity_z,
    output logic [7:0]         o_bounces_left_out,
    output logic               o_last_out
);

    localparam int unsigned NSTAGE = 4;

    t_word             r_ground_height;
    t_word             r_bounce_scale;
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] w_en;
    t_particle         w_in_item;
    t_side             w_side;
    t_scale_ctl        w_scale_ctl;
    t_resolve_ctl      w_res_ctl;
    t_word             w_vel_x;
    t_word             w_vel_y;
    t_word             w_vel_z;
    t_particle         w_out_item;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NSTAGE-1];

    // valid bits and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld           <= '0;
            r_ground_height <= '0;
            r_bounce_scale  <= t_word'(1 <<< Q_FRAC_BITS);
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_GROUND_HEIGHT: r_ground_height <= i_cfg_data;
                    CFG_BOUNCE_SCALE:  r_bounce_scale  <= i_cfg_data;
                endcase
            end
        end
    end

    // input word
    always_comb begin
        w_in_item.px      = i_position_x;
        w_in_item.py      = i_position_y;
        w_in_item.pz      = i_position_z;
        w_in_item.vx      = i_velocity_x;
        w_in_item.vy      = i_velocity_y;
        w_in_item.vz      = i_velocity_z;
        w_in_item.bounces = i_bounces_left_in;
        w_in_item.last    = i_last_in;
    end

    assign w_scale_ctl.load_mul = w_en[1];
    assign w_scale_ctl.load_sat = w_en[2];
    assign w_res_ctl.load_s2    = w_en[1];
    assign w_res_ctl.load_s3    = w_en[2];
    assign w_res_ctl.load_out   = w_en[3];

    pgb_front u_front (
        .i_clk    (i_clk),
        .i_load   (w_en[0]),
        .i_item   (w_in_item),
        .i_ground (r_ground_height),
        .o_side   (w_side)
    );

    pgb_scale u_scale_x (
        .i_clk    (i_clk),
        .i_ctl    (w_scale_ctl),
        .i_negate (1'b0),
        .i_scale  (r_bounce_scale),
        .i_vel    (w_side.item.vx),
        .o_vel    (w_vel_x)
    );

    pgb_scale u_scale_y (
        .i_clk    (i_clk),
        .i_ctl    (w_scale_ctl),
        .i_negate (1'b1),
        .i_scale  (r_bounce_scale),
        .i_vel    (w_side.item.vy),
        .o_vel    (w_vel_y)
    );

    pgb_scale u_scale_z (
        .i_clk    (i_clk),
        .i_ctl    (w_scale_ctl),
        .i_negate (1'b0),
        .i_scale  (r_bounce_scale),
        .i_vel    (w_side.item.vz),
        .o_vel    (w_vel_z)
    );

    pgb_resolve u_resolve (
        .i_clk    (i_clk),
        .i_ctl    (w_res_ctl),
        .i_side   (w_side),
        .i_ground (r_ground_height),
        .i_vel_x  (w_vel_x),
        .i_vel_y  (w_vel_y),
        .i_vel_z  (w_vel_z),
        .o_item   (w_out_item)
    );

    // output word
    assign o_new_position_x   = w_out_item.px;
    assign o_new_position_y   = w_out_item.py;
    assign o_new_position_z   = w_out_item.pz;
    assign o_new_velocity_x   = w_out_item.vx;
    assign o_new_velocity_y   = w_out_item.vy;
    assign o_new_velocity_z   = w_out_item.vz;
    assign o_bounces_left_out = w_out_item.bounces;
    assign o_last_out         = w_out_item.last;

endmodule

### rtl/pgb_front.sv
// entry stage: captures the particle word and finds ground contact
module pgb_front
    import pgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  t_particle i_item,
    input  t_word     i_ground,
    output t_side     o_side
);

    t_side r_side;
    t_side n_side;

    // contact test against the ground plane
    always_comb begin
        n_side.item  = i_item;
        n_side.below = (i_item.py < i_ground);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_side <= n_side;
        end
    end

    assign o_side = r_side;

endmodule

### rtl/pgb_scale.sv
// one velocity axis: q16.16 multiply, then optional negate, floor shift and clamp
module pgb_scale
    import pgb_pkg::*;
(
    input  logic       i_clk,
    input  t_scale_ctl i_ctl,
    input  logic       i_negate,
    input  t_word      i_scale,
    input  t_word      i_vel,
    output t_word      o_vel
);

    t_prod r_prod;
    t_prod n_prod;
    t_word r_vel;
    t_word n_vel;
    t_prod w_adj;
    logic signed [SHIFT_W-1:0] w_shift;

    // full 64-bit product
    assign n_prod = PROD_W'(i_vel) * PROD_W'(i_scale);

    // negate exactly, arithmetic shift rounds toward minus infinity
    always_comb begin
        w_adj   = i_negate ? -r_prod : r_prod;
        w_shift = w_adj[PROD_W-1:Q_FRAC_BITS];
        n_vel   = sat_shifted(w_shift);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            r_prod <= n_prod;
        end
        if (i_ctl.load_sat) begin
            r_vel <= n_vel;
        end
    end

    assign o_vel = r_vel;

endmodule

### rtl/pgb_resolve.sv
// side pipeline alongside the multipliers and the final position update
module pgb_resolve
    import pgb_pkg::*;
(
    input  logic         i_clk,
    input  t_resolve_ctl i_ctl,
    input  t_side        i_side,
    input  t_word        i_ground,
    input  t_word        i_vel_x,
    input  t_word        i_vel_y,
    input  t_word        i_vel_z,
    output t_particle    o_item
);

    t_side     r_s2;
    t_side     r_s3;
    t_particle r_out;
    t_particle n_out;
    t_word     w_py;

    // bounce, stick or pass through
    always_comb begin
        n_out = r_s3.item;
        w_py  = sat_add(r_s3.item.py, i_vel_y);
        if (r_s3.below) begin
            if (r_s3.item.bounces != '0) begin
                n_out.bounces = r_s3.item.bounces - CNT_W'(1);
                n_out.vx      = i_vel_x;
                n_out.vy      = i_vel_y;
                n_out.vz      = i_vel_z;
                n_out.px      = sat_add(r_s3.item.px, i_vel_x);
                n_out.pz      = sat_add(r_s3.item.pz, i_vel_z);
                n_out.py      = (w_py < i_ground) ? i_ground : w_py;
            end else begin
                n_out.vx = '0;
                n_out.vy = '0;
                n_out.vz = '0;
                n_out.py = i_ground;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s2) begin
            r_s2 <= i_side;
        end
        if (i_ctl.load_s3) begin
            r_s3 <= r_s2;
        end
        if (i_ctl.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

### rtl/pgb_checker.sv
// port-level checks of the particle ground bounce block and their binding
`include "particle_ground_bounce_core_assert.svh"

module pgb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_new_position_x,
    input logic signed [31:0] o_new_position_y,
    input logic signed [31:0] o_new_position_z,
    input logic signed [31:0] o_new_velocity_x,
    input logic signed [31:0] o_new_velocity_y,
    input logic signed [31:0] o_new_velocity_z,
    input logic [7:0]         o_bounces_left_out,
    input logic               o_last_out
);

    // a held output word keeps its valid and its payload
    `PGB_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_new_position_x) && $stable(o_new_position_y) && $stable(o_new_position_z) && $stable(o_new_velocity_x) && $stable(o_new_velocity_y) && $stable(o_new_velocity_z) && $stable(o_bounces_left_out) && $stable(o_last_out), "held output word changed")

    // reset empties the pipeline
    `PGB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // back-pressure only comes from a held, full output
    `PGB_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled without output back-pressure")

    // a full pipeline whose output is taken opens the input
    `PGB_ASSERT(a_drain_opens, i_clk, i_rst_n, o_valid && !i_stall |-> !o_stall, "input stalled while output drains")

endmodule

bind particle_ground_bounce_core pgb_checker u_pgb_checker (.*);

### test/particle_ground_bounce_checker.sv
// checker for the particle ground bounce block: predicts each output word and compares it
module particle_ground_bounce_checker
    import pgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [WORD_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    input  logic signed [31:0] i_position_z,
    input  logic signed [31:0] i_velocity_x,
    input  logic signed [31:0] i_velocity_y,
    input  logic signed [31:0] i_velocity_z,
    input  logic [7:0]         i_bounces_left_in,
    input  logic               i_last_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_new_position_x,
    input  logic signed [31:0] i_new_position_y,
    input  logic signed [31:0] i_new_position_z,
    input  logic signed [31:0] i_new_velocity_x,
    input  logic signed [31:0] i_new_velocity_y,
    input  logic signed [31:0] i_new_velocity_z,
    input  logic [7:0]         i_bounces_left_out,
    input  logic               i_last_out,
    output int                 o_error_count,
    output int                 o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    t_word     ground_level;
    t_word     rebound_scale;
    t_particle bounced_q[$];
    int        error_count = 0;

    // q16.16 product, optionally negated, floored and clamped to a word
    function automatic t_word scale_axis(input t_word v, input t_word s, input bit flip);
        t_prod wv;
        t_prod ws;
        t_prod p;
        t_prod q;
        t_word res;
        wv = v;
        ws = s;
        p = wv * ws;
        if (flip) begin
            p = -p;
        end
        q = p >>> Q_FRAC_BITS;
        if (q > WORD_MAX) begin
            res = WORD_MAX;
        end else if (q < WORD_MIN) begin
            res = WORD_MIN;
        end else begin
            res = q[WORD_W-1:0];
        end
        return res;
    endfunction

    // word add clamped to the signed range
    function automatic t_word add_clamped(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        t_word                  res;
        s = a + b;
        if (s > WORD_MAX) begin
            res = WORD_MAX;
        end else if (s < WORD_MIN) begin
            res = WORD_MIN;
        end else begin
            res = s[WORD_W-1:0];
        end
        return res;
    endfunction

    // one particle through the ground plane test
    function automatic t_particle bounce_particle(input t_particle w, input t_word ground,
                                                  input t_word scale);
        t_particle r;
        t_word     py;
        t_word     vx;
        t_word     vy;
        t_word     vz;
        r  = w;
        py = w.py;
        if (py < ground) begin
            if (w.bounces != '0) begin
                r.bounces = w.bounces - 1'b1;
                vx = scale_axis(w.vx, scale, 1'b0);
                vy = scale_axis(w.vy, scale, 1'b1);
                vz = scale_axis(w.vz, scale, 1'b0);
                r.vx = vx;
                r.vy = vy;
                r.vz = vz;
                r.px = add_clamped(w.px, vx);
                r.pz = add_clamped(w.pz, vz);
                py   = add_clamped(py, vy);
                r.py = (py < ground) ? ground : py;
            end else begin
                r.vx = '0;
                r.vy = '0;
                r.vz = '0;
                r.py = ground;
            end
        end
        return r;
    endfunction

    // one field compare, reported on mismatch
    function automatic int field_bad(input string name, input logic [WORD_W-1:0] want,
                                     input logic [WORD_W-1:0] got);
        int bad;
        bad = 0;
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            bad = 1;
        end
        return bad;
    endfunction

    // track registers, queue predictions, check output words
    always @(posedge i_clk) begin
        t_particle want;
        t_particle got;
        t_particle taken;
        int        bad;
        if (!i_rst_n) begin
            ground_level  = '0;
            rebound_scale = 32'sh0001_0000;
            bounced_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.px      = i_new_position_x;
                got.py      = i_new_position_y;
                got.pz      = i_new_position_z;
                got.vx      = i_new_velocity_x;
                got.vy      = i_new_velocity_y;
                got.vz      = i_new_velocity_z;
                got.bounces = i_bounces_left_out;
                got.last    = i_last_out;
                if (bounced_q.size() == 0) begin
                    $display("%0t ns: output word with none expected, actual %h", $time, got);
                    error_count++;
                end else begin
                    want = bounced_q.pop_front();
                    bad  = field_bad("new_position_x", want.px, got.px)
                         + field_bad("new_position_y", want.py, got.py)
                         + field_bad("new_position_z", want.pz, got.pz)
                         + field_bad("new_velocity_x", want.vx, got.vx)
                         + field_bad("new_velocity_y", want.vy, got.vy)
                         + field_bad("new_velocity_z", want.vz, got.vz)
                         + field_bad("bounces_left_out", want.bounces, got.bounces)
                         + field_bad("last_out", want.last, got.last);
                    if (bad != 0) begin
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                taken.px      = i_position_x;
                taken.py      = i_position_y;
                taken.pz      = i_position_z;
                taken.vx      = i_velocity_x;
                taken.vy      = i_velocity_y;
                taken.vz      = i_velocity_z;
                taken.bounces = i_bounces_left_in;
                taken.last    = i_last_in;
                bounced_q.push_back(bounce_particle(taken, ground_level, rebound_scale));
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_GROUND_HEIGHT: ground_level  = i_cfg_data;
                    CFG_BOUNCE_SCALE:  rebound_scale = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_in_flight   <= bounced_q.size();
        o_error_count <= error_count;
    end

endmodule

### test/tb_particle_ground_bounce_core.sv
// testbench top for the particle ground bounce block: stimulus, stalls and verdict
module tb_particle_ground_bounce_core;
    import pgb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [WORD_W-1:0]  i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_position_x;
    logic signed [31:0] i_position_y;
    logic signed [31:0] i_position_z;
    logic signed [31:0] i_velocity_x;
    logic signed [31:0] i_velocity_y;
    logic signed [31:0] i_velocity_z;
    logic [7:0]         i_bounces_left_in;
    logic               i_last_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_new_position_x;
    logic signed [31:0] o_new_position_y;
    logic signed [31:0] o_new_position_z;
    logic signed [31:0] o_new_velocity_x;
    logic signed [31:0] o_new_velocity_y;
    logic signed [31:0] o_new_velocity_z;
    logic [7:0]         o_bounces_left_out;
    logic               o_last_out;

    int error_count;
    int in_flight;
    int tx_idle_pct = 37;
    bit rx_quiet    = 1'b0;
    bit hold_req    = 1'b0;

    particle_ground_bounce_core dut (.*);

    particle_ground_bounce_checker u_bounce_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_position_x       (i_position_x),
        .i_position_y       (i_position_y),
        .i_position_z       (i_position_z),
        .i_velocity_x       (i_velocity_x),
        .i_velocity_y       (i_velocity_y),
        .i_velocity_z       (i_velocity_z),
        .i_bounces_left_in  (i_bounces_left_in),
        .i_last_in          (i_last_in),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_new_position_x   (o_new_position_x),
        .i_new_position_y   (o_new_position_y),
        .i_new_position_z   (o_new_position_z),
        .i_new_velocity_x   (o_new_velocity_x),
        .i_new_velocity_y   (o_new_velocity_y),
        .i_new_velocity_z   (o_new_velocity_z),
        .i_bounces_left_out (o_bounces_left_out),
        .i_last_out         (o_last_out),
        .o_error_count      (error_count),
        .o_in_flight        (in_flight)
    );

    // 20 ns clock
    always begin
        #10;
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_particle particle_of(input t_word px, input t_word py, input t_word pz,
                                              input t_word vx, input t_word vy, input t_word vz,
                                              input logic [CNT_W-1:0] bounces, input logic last);
        t_particle w;
        w.px      = px;
        w.py      = py;
        w.pz      = pz;
        w.vx      = vx;
        w.vy      = vy;
        w.vz      = vz;
        w.bounces = bounces;
        w.last    = last;
        return w;
    endfunction

    // mix of extremes, full-range words and small values
    function automatic t_word random_q();
        t_word v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(6))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = '0;
                    3: v = -1;
                    4: v = 1;
                    5: v = 32'sh0001_0000;
                    default: v = -32'sh0001_0000;
                endcase
            end
            1, 2, 3, 4: v = $urandom;
            default: v = t_word'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
        return v;
    endfunction

    // random particle, mostly near or under the ground plane
    function automatic t_particle random_particle(input t_word ground);
        t_word            py;
        logic [CNT_W-1:0] bounces;
        case ($urandom_range(9))
            0, 1, 2, 3: py = ground - t_word'($urandom_range(32'h0004_0000));
            4: py = ground;
            5: py = ground - 1;
            default: py = random_q();
        endcase
        case ($urandom_range(7))
            0, 1: bounces = '0;
            2: bounces = 8'd1;
            3: bounces = 8'hFF;
            default: bounces = $urandom_range(255);
        endcase
        return particle_of(random_q(), py, random_q(), random_q(), random_q(), random_q(),
                           bounces, ($urandom_range(7) == 0));
    endfunction

    // offer one word, wait for it to be taken, then maybe idle
    task automatic offer_particle(input t_particle w);
        i_valid           <= 1'b1;
        i_position_x      <= w.px;
        i_position_y      <= w.py;
        i_position_z      <= w.pz;
        i_velocity_x      <= w.vx;
        i_velocity_y      <= w.vy;
        i_velocity_z      <= w.vz;
        i_bounces_left_in <= w.bounces;
        i_last_in         <= w.last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write both registers on an empty pipeline
    task automatic load_ground_and_scale(input t_word ground, input t_word scale);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GROUND_HEIGHT;
        i_cfg_data  <= ground;
        @(posedge i_clk);
        i_cfg_index <= CFG_BOUNCE_SCALE;
        i_cfg_data  <= scale;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // output side stalls: random, quiet, or one long hold-off
    initial begin
        int held;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                held = 0;
                while (held < 100) begin
                    @(posedge i_clk);
                    held++;
                end
                i_stall <= 1'b0;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 37);
            end
        end
    end

    // reset, directed words, then random phases over several register settings
    initial begin
        t_word grounds[8];
        t_word scales[8];
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_GROUND_HEIGHT;
        i_cfg_data        <= '0;
        i_valid           <= 1'b0;
        i_position_x      <= '0;
        i_position_y      <= '0;
        i_position_z      <= '0;
        i_velocity_x      <= '0;
        i_velocity_y      <= '0;
        i_velocity_z      <= '0;
        i_bounces_left_in <= '0;
        i_last_in         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ground 0, scale 1.0
        offer_particle(particle_of(32'sh0064_0000, 32'sh0064_0000, -32'sh0010_0000,
                                   32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 3, 0));
        offer_particle(particle_of(32'sh0005_0000, 0, 7, 1, -1, 2, 3, 0));
        offer_particle(particle_of(32'sh0001_0000, -1, 32'sh0002_0000,
                                   32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 3, 0));
        offer_particle(particle_of(11, -32'sh0003_0000, -5, 32'sh0004_0000, -9, 13, 0, 0));
        offer_particle(particle_of(-7, -32'sh0000_4000, 9, -3, -32'sh0001_0000, 5, 8'hFF, 1));
        // position plus velocity past either end of the range
        offer_particle(particle_of(WORD_MAX, -1, 0, WORD_MAX, 0, 0, 1, 0));
        offer_particle(particle_of(WORD_MIN, -1, WORD_MIN, WORD_MIN, 0, WORD_MIN, 2, 0));
        offer_particle(particle_of(0, WORD_MIN, 0, 0, WORD_MAX, 0, 7, 0));

        // half scale: products of small negatives round toward minus infinity
        load_ground_and_scale('0, 32'sh0000_8000);
        offer_particle(particle_of(0, -2, 0, -1, 1, 3, 4, 0));
        offer_particle(particle_of(5, -32'sh0001_0000, -5, -3, -1, WORD_MIN, 1, 1));

        // highest ground, most negative scale: products clamp
        load_ground_and_scale(WORD_MAX, WORD_MIN);
        offer_particle(particle_of(0, WORD_MIN, 0, WORD_MIN, WORD_MIN, WORD_MAX, 1, 0));
        offer_particle(particle_of(3, WORD_MAX, 4, 5, 6, 7, 2, 1));
        offer_particle(particle_of(1, WORD_MAX - 1, 2, 3, 4, 5, 0, 0));
        offer_particle(particle_of(0, 0, 0, 1, -1, 0, 8'd200, 0));

        // lowest ground, largest scale: nothing is below ground
        load_ground_and_scale(WORD_MIN, WORD_MAX);
        offer_particle(particle_of(1, WORD_MIN, 2, WORD_MAX, WORD_MAX, WORD_MIN, 5, 0));
        offer_particle(particle_of(-1, WORD_MAX, -2, 3, WORD_MIN, 4, 0, 1));

        // zero scale: a bounce stops the particle at ground
        load_ground_and_scale(32'sh0001_8000, '0);
        offer_particle(particle_of(9, 0, 8, 32'sh0003_0000, -32'sh0003_0000, 1, 9, 0));
        offer_particle(particle_of(9, 32'sh0001_7FFF, 8, 7, 6, 5, 0, 1));

        // register settings of the random phases
        grounds[0] = '0;
        scales[0]  = 32'sh0001_0000;
        grounds[1] = t_word'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        scales[1]  = 32'sh0000_CCCD;
        grounds[2] = WORD_MIN;
        scales[2]  = WORD_MAX;
        grounds[3] = WORD_MAX;
        scales[3]  = WORD_MIN;
        grounds[4] = '0;
        scales[4]  = '0;
        grounds[5] = $urandom;
        scales[5]  = $urandom;
        grounds[6] = -32'sh0003_0000;
        scales[6]  = -32'sh0001_0000;
        grounds[7] = t_word'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        scales[7]  = 32'sh0003_0000 + t_word'($urandom_range(32'h0000_FFFF));

        for (int ph = 0; ph < 8; ph++) begin
            load_ground_and_scale(grounds[ph], scales[ph]);
            // one phase runs with no idling on either side
            tx_idle_pct = (ph == 2) ? 0 : 37;
            rx_quiet    = (ph == 2);
            for (int n = 0; n < 192; n++) begin
                // long output hold-off while input keeps coming, so the pipe fills
                if (ph == 4) begin
                    if (n == 60) begin
                        hold_req = 1'b1;
                    end
                    tx_idle_pct = (n >= 60 && n < 100) ? 0 : 37;
                end
                // pause mid-phase until all words are out
                if (ph == 5 && n == 96) begin
                    drain();
                end
                offer_particle(random_particle(grounds[ph]));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
